@@ rtl/core/rme_pkg.sv @@
// Package: payload types and CORDIC constants for the rotation matrix to Euler core
`timescale 1ns / 1ps
package rme_pkg;
	typedef struct packed {
		logic signed [15:0] r00;
		logic signed [15:0] r10;
		logic signed [15:0] r11;
		logic signed [15:0] r12;
		logic signed [15:0] r20;
		logic signed [15:0] r21;
		logic signed [15:0] r22;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic               singular;
	} out_item_t;

	localparam int TableLen = 24;
	localparam int GuardShift = 8;
	localparam int AngleLimit = 23040;
	localparam int SqrtSteps = 16;

	function automatic logic [31:0] atan_q24(input int i);
		logic [31:0] t;
		begin
			unique case (i)
				0: t = 32'd754974720;
				1: t = 32'd445687602;
				2: t = 32'd235489088;
				3: t = 32'd119537938;
				4: t = 32'd60000934;
				5: t = 32'd30029717;
				6: t = 32'd15018523;
				7: t = 32'd7509720;
				8: t = 32'd3754917;
				9: t = 32'd1877466;
				10: t = 32'd938734;
				11: t = 32'd469367;
				12: t = 32'd234684;
				13: t = 32'd117342;
				14: t = 32'd58671;
				15: t = 32'd29335;
				16: t = 32'd14668;
				17: t = 32'd7334;
				18: t = 32'd3667;
				19: t = 32'd1833;
				20: t = 32'd917;
				21: t = 32'd458;
				22: t = 32'd229;
				23: t = 32'd115;
				default: t = 32'd0;
			endcase
			return t;
		end
	endfunction
endpackage

@@ rtl/core/rme_sqrt.sv @@
// Pipelined bit-by-bit integer square root of r00^2 + r10^2, one result bit per stage
`timescale 1ns / 1ps
module rme_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic signed [15:0] a,
	input  logic signed [15:0] b,
	output logic [16:0] root
);
	localparam int N = rme_pkg::SqrtSteps;
	logic [32:0] rem_s [N+1];
	logic [32:0] rt_s  [N+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= 33'(32'(a * a) + 32'(b * b));
			rt_s[0]  <= '0;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_st
		localparam logic [33:0] Bit = 34'd1 << (2 * (N - 1 - k));
		logic [33:0] trial;
		assign trial = 34'(rt_s[k]) + Bit;
		always_ff @(posedge clk) begin
			if (en) begin
				if (34'(rem_s[k]) >= trial) begin
					rem_s[k+1] <= 33'(34'(rem_s[k]) - trial);
					rt_s[k+1]  <= 33'((34'(rt_s[k]) >> 1) + Bit);
				end else begin
					rem_s[k+1] <= rem_s[k];
					rt_s[k+1]  <= rt_s[k] >> 1;
				end
			end
		end
	end

	assign root = rt_s[N][16:0];
	logic unused;
	assign unused = arst_n ^ (^rt_s[N][32:17]) ^ (^rem_s[N]);
endmodule

@@ rtl/core/rme_cordic.sv @@
// Pipelined vectoring CORDIC atan2 giving degrees in 1/128 units, saturated
`timescale 1ns / 1ps
module rme_cordic #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        en,
	input  logic signed [17:0] y_in,
	input  logic signed [17:0] x_in,
	output logic signed [15:0] angle
);
	localparam int W = 18 + rme_pkg::GuardShift + 3;
	localparam int ZW = FRAC_BITS + 11;
	localparam int N = CORDIC_STEPS;

	logic signed [W-1:0]  x_s [N+1];
	logic signed [W-1:0]  y_s [N+1];
	logic signed [ZW-1:0] z_s [N+1];
	logic                 zero_s [N+2];
	logic signed [ZW-1:0] z90;
	logic signed [W-1:0]  xg, yg;

	assign z90 = ZW'(90) <<< FRAC_BITS;
	assign xg = W'(x_in) <<< rme_pkg::GuardShift;
	assign yg = W'(y_in) <<< rme_pkg::GuardShift;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (xg < 0) begin
				if (yg >= 0) begin
					x_s[0] <= yg; y_s[0] <= -xg; z_s[0] <= z90;
				end else begin
					x_s[0] <= -yg; y_s[0] <= xg; z_s[0] <= -z90;
				end
			end else begin
				x_s[0] <= xg; y_s[0] <= yg; z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_it
		localparam logic [31:0] Ang = 32'((64'(rme_pkg::atan_q24(i)) +
			(64'd1 << (23 - FRAC_BITS))) >> (24 - FRAC_BITS));
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ZW'(Ang);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ZW'(Ang);
				end
			end
		end
	end

	logic signed [ZW-1:0] zr;
	assign zr = (z_s[N] + (ZW'(1) <<< (FRAC_BITS - 8))) >>> (FRAC_BITS - 7);

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[N+1] <= zero_s[N];
			if (zero_s[N])
				angle <= '0;
			else if (zr > ZW'(rme_pkg::AngleLimit))
				angle <= 16'(rme_pkg::AngleLimit);
			else if (zr < -ZW'(rme_pkg::AngleLimit))
				angle <= -16'(rme_pkg::AngleLimit);
			else
				angle <= 16'(zr);
		end
	end

	logic unused;
	assign unused = zero_s[N+1] ^ x_s[N][0] ^ y_s[N][0];
endmodule

@@ rtl/core/rotation_matrix_to_euler_core.sv @@
// Top level: rotation matrix to ZYX Euler angles, pipelined square root and CORDIC
//  channel | dir | handshake            | payload
//  item    | in  | start & !busy        | in_item (rme_pkg::in_item_t)
//  result  | out | done, one cycle      | result (rme_pkg::out_item_t)
//  cfg     | in  | cfg_valid & cfg_ready| cfg_data, singular threshold
// One item per cycle; each item passes the square root stages, then the CORDIC stages.
// busy is always low.
// Reset clears valid bits and sets the threshold to 1. No stalls: results cannot be held.
`timescale 1ns / 1ps
module rotation_matrix_to_euler_core #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  rme_pkg::in_item_t    in_item,
	output logic                 done,
	output rme_pkg::out_item_t   result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [14:0]          cfg_data
);
	localparam int SL = rme_pkg::SqrtSteps + 1;
	localparam int CL = CORDIC_STEPS + 2;
	localparam int TOT = SL + CL;

	logic [14:0] thr_q;
	logic        vld_s [TOT+1];
	rme_pkg::in_item_t d_s [SL+1];
	logic [16:0] sy;
	logic        sing_s [CL+1];
	logic signed [17:0] ry, rx;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 15'd1;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= TOT; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= start;
			for (int k = 0; k < TOT; k++) vld_s[k+1] <= vld_s[k];
		end
	end

	always_ff @(posedge clk) begin
		d_s[0] <= in_item;
		for (int k = 0; k < SL; k++) d_s[k+1] <= d_s[k];
	end

	rme_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(1'b1),
		.a(in_item.r00), .b(in_item.r10), .root(sy)
	);

	rme_pkg::in_item_t m;
	logic sing;
	assign m = d_s[SL-1];
	assign sing = 17'(thr_q) > sy;
	assign ry = sing ? -18'(m.r12) : 18'(m.r21);
	assign rx = sing ? 18'(m.r11) : 18'(m.r22);

	always_ff @(posedge clk) begin
		sing_s[0] <= sing;
		for (int k = 0; k < CL; k++) sing_s[k+1] <= sing_s[k];
	end

	logic signed [15:0] roll_a, pitch_a, yaw_a;

	rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_roll (
		.clk(clk), .en(1'b1), .y_in(ry), .x_in(rx), .angle(roll_a)
	);
	rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_pitch (
		.clk(clk), .en(1'b1), .y_in(-18'(m.r20)), .x_in(18'(sy)), .angle(pitch_a)
	);
	rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_yaw (
		.clk(clk), .en(1'b1), .y_in(18'(m.r10)), .x_in(18'(m.r00)), .angle(yaw_a)
	);

	assign done = vld_s[TOT-1];
	assign result.roll = roll_a;
	assign result.pitch = pitch_a;
	assign result.yaw = sing_s[CL-1] ? 16'sd0 : yaw_a;
	assign result.singular = sing_s[CL-1];

	logic unused;
	assign unused = vld_s[TOT] ^ sing_s[CL] ^ (^d_s[SL]);
endmodule
